// File: rtl/core/reas_pkg.sv
package reas_pkg;

   // Width of the tracked value (allowed range 8 to 32)
   localparam int VALUE_BITS = 16;

   // Limit registers and configuration port
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = CFG_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_VALUE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VALUE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNIT_MODE = 2'd2;

   localparam logic signed [CFG_BITS-1:0] MIN_VALUE_RESET = 16'sd0;
   localparam logic signed [CFG_BITS-1:0] MAX_VALUE_RESET = 16'sd127;

   // Timestamp and detent speed thresholds, in ms
   localparam int TIME_BITS = 32;
   localparam logic [TIME_BITS-1:0] FAST_LIMIT_0 = 32'd5;
   localparam logic [TIME_BITS-1:0] FAST_LIMIT_1 = 32'd10;
   localparam logic [TIME_BITS-1:0] FAST_LIMIT_2 = 32'd20;
   localparam logic [TIME_BITS-1:0] FAST_LIMIT_3 = 32'd40;

   // Acceleration step
   localparam int STEP_BITS = 8;
   localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

   // Span is max - min, clipped at zero: fits the limit width unsigned
   localparam int SPAN_BITS  = CFG_BITS;
   localparam int RECIP_BITS = 17;
   localparam int PROD_BITS  = SPAN_BITS + RECIP_BITS;

   // floor(x / d) == (x * m) >> k, exact for every 16-bit x
   localparam int SHIFT_8 = 3;
   localparam logic [RECIP_BITS-1:0] RECIP_10   = 17'd52429;
   localparam int                    SHIFT_10   = 19;
   localparam logic [RECIP_BITS-1:0] RECIP_15   = 17'd69906;
   localparam int                    SHIFT_15   = 20;
   localparam logic [RECIP_BITS-1:0] RECIP_20   = 17'd52429;
   localparam int                    SHIFT_20   = 20;
   localparam logic [RECIP_BITS-1:0] RECIP_1000 = 17'd67109;
   localparam int                    SHIFT_1000 = 26;

   typedef struct packed {
      logic                 pin_a;
      logic                 pin_b;
      logic [TIME_BITS-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         detent_seen;
   } rsp_word_type;

   // Step per speed band, fastest first
   typedef struct packed {
      logic [STEP_BITS-1:0] step_8;
      logic [STEP_BITS-1:0] step_10;
      logic [STEP_BITS-1:0] step_15;
      logic [STEP_BITS-1:0] step_20;
      logic [STEP_BITS-1:0] step_1000;
   } step_set_type;

endpackage

// File: rtl/core/reas_step_table.sv
module reas_step_table (
   input  logic                                clock,
   input  logic signed [reas_pkg::CFG_BITS-1:0] min_value,
   input  logic signed [reas_pkg::CFG_BITS-1:0] max_value,
   output reas_pkg::step_set_type              step_set
);
   import reas_pkg::*;

   logic signed [CFG_BITS:0] span_diff;
   logic [SPAN_BITS-1:0]     span;
   logic [PROD_BITS-1:0]     span_wide;
   logic [PROD_BITS-1:0]     prod_10;
   logic [PROD_BITS-1:0]     prod_15;
   logic [PROD_BITS-1:0]     prod_20;
   logic [PROD_BITS-1:0]     prod_1000;
   step_set_type             step_set_in;
   step_set_type             step_set_ff;

   // 0 becomes 1, anything above the step range saturates
   function automatic logic [STEP_BITS-1:0] clip_step(input logic [PROD_BITS-1:0] q);
      logic [STEP_BITS-1:0] r;
      if (q == '0) begin
         r = STEP_BITS'(1);
      end else if (q > PROD_BITS'(STEP_MAX)) begin
         r = STEP_MAX;
      end else begin
         r = q[STEP_BITS-1:0];
      end
      return r;
   endfunction

   always_comb begin
      span_diff = (CFG_BITS+1)'(max_value) - (CFG_BITS+1)'(min_value);
      // inverted limits count as an empty span
      span      = span_diff[CFG_BITS] ? '0 : span_diff[SPAN_BITS-1:0];
      span_wide = PROD_BITS'(span);
      prod_10   = span_wide * PROD_BITS'(RECIP_10);
      prod_15   = span_wide * PROD_BITS'(RECIP_15);
      prod_20   = span_wide * PROD_BITS'(RECIP_20);
      prod_1000 = span_wide * PROD_BITS'(RECIP_1000);

      step_set_in.step_8    = clip_step(span_wide >> SHIFT_8);
      step_set_in.step_10   = clip_step(prod_10 >> SHIFT_10);
      step_set_in.step_15   = clip_step(prod_15 >> SHIFT_15);
      step_set_in.step_20   = clip_step(prod_20 >> SHIFT_20);
      step_set_in.step_1000 = clip_step(prod_1000 >> SHIFT_1000);
   end

   always_ff @(posedge clock) begin
      step_set_ff <= step_set_in;
   end

   assign step_set = step_set_ff;

endmodule

// File: rtl/core/rotary_encoder_accel_stepper.sv
// Rotary encoder stepper with speed-dependent acceleration. Each req word is one sample
// of encoder pins A and B with its millisecond timestamp; each sample yields exactly one
// rsp word with the current value and a flag set when that sample finished a detent
// (rise then fall of A). The block takes one sample per clock while the output is not
// stalled; the input register feeds the result register, from which the result word is
// presented. The value update of a sample is combinational between these registers, so
// successive samples follow back to back. Step sizes for the five speed bands are
// recomputed each cycle from the limit registers by a registered reciprocal-multiply
// table, so new limits apply to samples accepted from the cycle after the write on.
// Writing a limit does not clamp the current value; the next detent does.
module rotary_encoder_accel_stepper (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  reas_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output reas_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_we,
   input  logic [reas_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [reas_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import reas_pkg::*;

   localparam int SUM_BITS = ((VALUE_BITS > CFG_BITS) ? VALUE_BITS : CFG_BITS) + 2;
   localparam logic signed [SUM_BITS-1:0] VAL_HI = SUM_BITS'((64'sd1 <<< (VALUE_BITS-1)) - 1);
   localparam logic signed [SUM_BITS-1:0] VAL_LO = -VAL_HI - SUM_BITS'(1);

   // configuration
   logic signed [CFG_BITS-1:0] min_value_ff;
   logic signed [CFG_BITS-1:0] max_value_ff;
   logic                       unit_mode_ff;

   // handshake
   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   logic         advance;

   // encoder state
   logic                         last_a_ff, last_a_in;
   logic                         last_dir_b_ff, last_dir_b_in;
   logic [1:0]                   edge_count_ff, edge_count_in;
   logic [TIME_BITS-1:0]         rise_time_ff, rise_time_in;
   logic signed [VALUE_BITS-1:0] current_value_ff, current_value_in;

   // datapath
   step_set_type            step_set;
   logic                    a_change;
   logic [1:0]              count_inc;
   logic                    detent;
   logic [TIME_BITS-1:0]    elapsed;
   logic [STEP_BITS-1:0]    step_band;
   logic [STEP_BITS-1:0]    step_use;
   logic                    go_down;
   logic signed [SUM_BITS-1:0] step_wide;
   logic signed [SUM_BITS-1:0] sum;
   logic signed [SUM_BITS-1:0] sat;
   logic signed [SUM_BITS-1:0] lim_lo;
   logic signed [SUM_BITS-1:0] lim_hi;
   logic signed [SUM_BITS-1:0] clamped;

   reas_step_table u_step_table (
      .clock     (clock),
      .min_value (min_value_ff),
      .max_value (max_value_ff),
      .step_set  (step_set)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff <= MIN_VALUE_RESET;
         max_value_ff <= MAX_VALUE_RESET;
         unit_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_VALUE: min_value_ff <= $signed(csr_wdata[CFG_BITS-1:0]);
            CSR_MAX_VALUE: max_value_ff <= $signed(csr_wdata[CFG_BITS-1:0]);
            CSR_UNIT_MODE: unit_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // edge tracking
   always_comb begin
      a_change      = in_word_ff.pin_a != last_a_ff;
      count_inc     = edge_count_ff + 2'd1;
      detent        = a_change && (count_inc == 2'd2) && !in_word_ff.pin_a;
      last_a_in     = in_word_ff.pin_a;
      edge_count_in = edge_count_ff;
      rise_time_in  = rise_time_ff;
      if (a_change) begin
         // a fall closes a detent or, without a rise before it, restarts
         if (!in_word_ff.pin_a && (count_inc == 2'd1 || count_inc == 2'd2)) begin
            edge_count_in = 2'd0;
         end else begin
            edge_count_in = count_inc;
         end
         if (in_word_ff.pin_a && count_inc == 2'd1) begin
            rise_time_in = in_word_ff.now_ms;
         end
      end
   end

   // step and value update
   always_comb begin
      elapsed = in_word_ff.now_ms - rise_time_ff;
      if (elapsed < FAST_LIMIT_0) begin
         step_band = step_set.step_8;
      end else if (elapsed < FAST_LIMIT_1) begin
         step_band = step_set.step_10;
      end else if (elapsed < FAST_LIMIT_2) begin
         step_band = step_set.step_15;
      end else if (elapsed < FAST_LIMIT_3) begin
         step_band = step_set.step_20;
      end else begin
         step_band = step_set.step_1000;
      end

      // direction change or menu mode moves by one
      if (unit_mode_ff || in_word_ff.pin_b != last_dir_b_ff) begin
         step_use = STEP_BITS'(1);
      end else begin
         step_use = step_band;
      end
      go_down   = unit_mode_ff ? !in_word_ff.pin_b : in_word_ff.pin_b;
      step_wide = $signed(SUM_BITS'(step_use));
      sum       = go_down ? SUM_BITS'(current_value_ff) - step_wide
                          : SUM_BITS'(current_value_ff) + step_wide;

      if (sum > VAL_HI) begin
         sat = VAL_HI;
      end else if (sum < VAL_LO) begin
         sat = VAL_LO;
      end else begin
         sat = sum;
      end

      lim_lo  = SUM_BITS'(min_value_ff);
      lim_hi  = SUM_BITS'(max_value_ff);
      clamped = (sat < lim_lo) ? lim_lo : sat;
      // max wins when the limits are inverted
      if (clamped > lim_hi) begin
         clamped = lim_hi;
      end

      if (detent) begin
         current_value_in = clamped[VALUE_BITS-1:0];
         last_dir_b_in    = in_word_ff.pin_b;
      end else begin
         current_value_in = current_value_ff;
         last_dir_b_in    = last_dir_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_a_ff        <= 1'b0;
         last_dir_b_ff    <= 1'b0;
         edge_count_ff    <= 2'd0;
         rise_time_ff     <= '0;
         current_value_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            last_a_ff        <= last_a_in;
            last_dir_b_ff    <= last_dir_b_in;
            edge_count_ff    <= edge_count_in;
            rise_time_ff     <= rise_time_in;
            current_value_ff <= current_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff.value       <= current_value_in;
         rsp_word_ff.detent_seen <= detent;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/core/reas_checker.sv
module reas_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input reas_pkg::rsp_word_type              rsp_word,
   input logic                                csr_we,
   input logic [reas_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [reas_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import reas_pkg::*;

   logic signed [VALUE_BITS-1:0] last_value_ff;
   logic signed [CFG_BITS-1:0]   min_ff;
   logic signed [CFG_BITS-1:0]   max_ff;

   // mirror of the limits and of the last delivered value
   always_ff @(posedge clock) begin
      if (reset) begin
         last_value_ff <= '0;
         min_ff        <= MIN_VALUE_RESET;
         max_ff        <= MAX_VALUE_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            last_value_ff <= rsp_word.value;
         end
         if (csr_we && csr_index == CSR_MIN_VALUE) begin
            min_ff <= $signed(csr_wdata[CFG_BITS-1:0]);
         end
         if (csr_we && csr_index == CSR_MAX_VALUE) begin
            max_ff <= $signed(csr_wdata[CFG_BITS-1:0]);
         end
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_idle_keeps_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.detent_seen |-> rsp_word.value == last_value_ff)
      else $error("value moved without a detent");

   a_detent_in_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.detent_seen && min_ff <= max_ff
         |-> rsp_word.value >= min_ff && rsp_word.value <= max_ff)
      else $error("detent value outside limits");

endmodule

bind rotary_encoder_accel_stepper reas_checker u_reas_checker (.*);

// File: tb/sv/encoder_value_checker.sv
`timescale 1ns / 100ps
module encoder_value_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  reas_pkg::req_word_type              req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  reas_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_we,
   input  logic [reas_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [reas_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding
);
   import reas_pkg::*;

   logic signed [CFG_BITS-1:0]   lo_limit;
   logic signed [CFG_BITS-1:0]   hi_limit;
   logic                         menu_mode;
   logic                         prev_a;
   logic                         dir_b;
   logic [1:0]                   edges;
   logic [TIME_BITS-1:0]         rise_ms;
   logic signed [VALUE_BITS-1:0] held_value;
   rsp_word_type                 pending_values[$];

   // Value the block should report after one sample; updates the tracked state.
   task automatic track_sample(input req_word_type w, output rsp_word_type r);
      longint               acc;
      longint               span;
      longint               ceil_v;
      longint               floor_v;
      longint               stride;
      logic [TIME_BITS-1:0] elapsed;
      r.detent_seen = 1'b0;
      if (w.pin_a != prev_a) begin
         prev_a = w.pin_a;
         edges = edges + 2'd1;
         if (edges == 2'd1) begin
            if (w.pin_a) begin
               rise_ms = w.now_ms;
            end else begin
               edges = 2'd0;
            end
         end
         if (edges == 2'd2 && !w.pin_a) begin
            edges = 2'd0;
            r.detent_seen = 1'b1;
            elapsed = w.now_ms - rise_ms;
            span = longint'(hi_limit) - longint'(lo_limit);
            if (span < 0) begin
               span = 0;
            end
            if (elapsed < FAST_LIMIT_0) begin
               stride = span / 8;
            end else if (elapsed < FAST_LIMIT_1) begin
               stride = span / 10;
            end else if (elapsed < FAST_LIMIT_2) begin
               stride = span / 15;
            end else if (elapsed < FAST_LIMIT_3) begin
               stride = span / 20;
            end else begin
               stride = span / 1000;
            end
            if (stride == 0) begin
               stride = 1;
            end
            if (stride > longint'(STEP_MAX)) begin
               stride = longint'(STEP_MAX);
            end
            acc = longint'(held_value);
            if (menu_mode) begin
               // menu encoder: unit step, direction flipped
               acc = w.pin_b ? acc + 1 : acc - 1;
            end else begin
               if (w.pin_b != dir_b) begin
                  stride = 1;
               end
               acc = w.pin_b ? acc - stride : acc + stride;
            end
            ceil_v = (longint'(1) << (VALUE_BITS - 1)) - 1;
            floor_v = -ceil_v - 1;
            if (acc > ceil_v) begin
               acc = ceil_v;
            end
            if (acc < floor_v) begin
               acc = floor_v;
            end
            // min first, then max: with inverted limits max wins
            if (acc < longint'(lo_limit)) begin
               acc = longint'(lo_limit);
            end
            if (acc > longint'(hi_limit)) begin
               acc = longint'(hi_limit);
            end
            held_value = acc[VALUE_BITS-1:0];
            dir_b = w.pin_b;
         end
      end
      r.value = held_value;
   endtask

   always @(posedge clock) begin
      rsp_word_type guess;
      rsp_word_type head;
      if (reset) begin
         lo_limit = MIN_VALUE_RESET;
         hi_limit = MAX_VALUE_RESET;
         menu_mode = 1'b0;
         prev_a = 1'b0;
         dir_b = 1'b0;
         edges = 2'd0;
         rise_ms = '0;
         held_value = '0;
         pending_values.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_values.size() == 0) begin
               $error("unexpected rsp word: value %0d, detent_seen %0b",
                      rsp_word.value, rsp_word.detent_seen);
               mismatches++;
            end else begin
               head = pending_values.pop_front();
               if (rsp_word.value !== head.value) begin
                  $error("value: expected %0d, got %0d", head.value, rsp_word.value);
                  mismatches++;
               end
               if (rsp_word.detent_seen !== head.detent_seen) begin
                  $error("detent_seen: expected %0b, got %0b",
                         head.detent_seen, rsp_word.detent_seen);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            track_sample(req_word, guess);
            pending_values.push_back(guess);
         end
         // limits take effect for samples after the write
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_VALUE: lo_limit = csr_wdata;
               CSR_MAX_VALUE: hi_limit = csr_wdata;
               CSR_UNIT_MODE: menu_mode = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding = pending_values.size();
   end

endmodule

// File: tb/sv/rotary_encoder_accel_stepper_tb.sv
`timescale 1ns / 100ps
module rotary_encoder_accel_stepper_tb;
   import reas_pkg::*;

   localparam int IDLE_LIMIT      = 1000;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int PHASES          = 9;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_word_type              req_word = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int                        mismatches;
   int                        outstanding;
   int                        quiet_cycles = 0;
   int                        samples_sent = 0;
   logic                      burst = 1'b0;
   logic                      level_a = 1'b0;
   logic                      dir_hint = 1'b0;
   logic [TIME_BITS-1:0]      stamp = 32'd100;

   always #6 clock = ~clock;

   rotary_encoder_accel_stepper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   encoder_value_checker value_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // rsp side: random stall before each word, none in burst phases
   initial begin : rsp_side
      int stall;
      forever begin
         stall = burst ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Called and returns at a falling edge.
   task automatic send_sample(input logic a, input logic b, input logic [TIME_BITS-1:0] ms);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{pin_a: a, pin_b: b, now_ms: ms};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      level_a = a;
      samples_sent++;
   endtask

   task automatic turn_detent(input logic b, input logic [TIME_BITS-1:0] gap);
      send_sample(1'b1, b, stamp);
      stamp = stamp + gap;
      send_sample(1'b0, b, stamp);
      stamp = stamp + 32'd50;
   endtask

   function automatic logic [TIME_BITS-1:0] gap_ms();
      logic [TIME_BITS-1:0] lim;
      case ($urandom_range(0, 7))
         0, 7: return $urandom_range(0, 4);
         1: return $urandom_range(5, 9);
         2: return $urandom_range(10, 19);
         3: return $urandom_range(20, 39);
         4: return $urandom_range(40, 2000);
         5: begin
            // at a speed band boundary or just below it
            case ($urandom_range(0, 3))
               0: lim = FAST_LIMIT_0;
               1: lim = FAST_LIMIT_1;
               2: lim = FAST_LIMIT_2;
               default: lim = FAST_LIMIT_3;
            endcase
            return lim - $urandom_range(0, 1);
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic apply_limits(input int lo, input int hi, input logic mode);
      csr_we <= 1'b1;
      csr_index <= CSR_MIN_VALUE;
      csr_wdata <= lo[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_index <= CSR_MAX_VALUE;
      csr_wdata <= hi[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_index <= CSR_UNIT_MODE;
      csr_wdata <= {15'($urandom), mode};
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly clean detents with random speed and direction, plus noise.
   task automatic random_turns(input int budget);
      int   stop_at;
      int   pick;
      logic b;
      stop_at = samples_sent + budget;
      while (samples_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            b = ($urandom_range(0, 3) != 0) ? dir_hint : 1'($urandom_range(0, 1));
            dir_hint = b;
            send_sample(1'b1, 1'($urandom), stamp);
            if ($urandom_range(0, 4) == 0) begin
               send_sample(1'b1, 1'($urandom), stamp + 32'd1);
            end
            stamp = stamp + gap_ms();
            send_sample(1'b0, b, stamp);
         end else if (pick == 7) begin
            send_sample(level_a, 1'($urandom), stamp);
         end else begin
            send_sample(1'($urandom), 1'($urandom), $urandom);
         end
         stamp = stamp + gap_ms();
      end
   endtask

   initial begin
      int   lo;
      int   hi;
      logic mode;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset limits 0..127: each speed band, direction change, timestamp wrap
      send_sample(1'b0, 1'b0, '0);
      turn_detent(1'b0, 32'd4);
      turn_detent(1'b0, 32'd5);
      turn_detent(1'b0, 32'd19);
      turn_detent(1'b0, 32'd39);
      turn_detent(1'b0, 32'd40);
      turn_detent(1'b1, 32'd0);
      stamp = 32'hFFFF_FFFE;
      turn_detent(1'b1, 32'd3);
      settle();
      apply_limits(-32768, 32767, 1'b0);
      turn_detent(1'b1, 32'd0);
      settle();
      apply_limits(100, -100, 1'b0);
      turn_detent(1'b0, 32'd0);
      settle();
      apply_limits(-5, 5, 1'b1);
      turn_detent(1'b1, 32'd7);
      turn_detent(1'b0, 32'd7);
      settle();
      apply_limits(7, 7, 1'b0);
      turn_detent(1'b1, 32'd100);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         mode = 1'b0;
         case (phase)
            // pull the value near a rail, then open the full range
            0: begin lo = 32000; hi = 32767; end
            1, 3: begin lo = -32768; hi = 32767; end
            2: begin lo = -32768; hi = -32000; end
            4: begin
               lo = int'($urandom_range(0, 32767));
               hi = lo - int'($urandom_range(1, 32767));
            end
            5: begin
               lo = -int'($urandom_range(0, 20));
               hi = int'($urandom_range(0, 20));
               mode = 1'b1;
            end
            6: begin
               lo = int'($urandom_range(0, 65535)) - 32768;
               hi = lo;
               mode = 1'($urandom);
            end
            7: begin
               lo = int'($urandom_range(0, 65535)) - 32768;
               hi = int'($urandom_range(0, 65535)) - 32768;
               mode = 1'($urandom);
            end
            default: begin
               lo = int'(MIN_VALUE_RESET);
               hi = int'(MAX_VALUE_RESET);
            end
         endcase
         apply_limits(lo, hi, mode);
         burst = (phase % 3 == 1);
         random_turns(ITEMS_PER_PHASE);
      end

      settle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: rotary_encoder_accel_stepper.f
rtl/core/reas_pkg.sv
rtl/core/reas_step_table.sv
rtl/core/rotary_encoder_accel_stepper.sv
rtl/core/reas_checker.sv
tb/sv/encoder_value_checker.sv
tb/sv/rotary_encoder_accel_stepper_tb.sv
